FILE: rtl/stme_pkg.sv
// Shared types and constants for the slider trimmed-mean EMA filter.
// Used by every module under rtl; depends on nothing else.
package stme_pkg;

  // Group size of the pitch bend trimmed mean (valid range 1..64).
  localparam int SAMPLES = 8;

  // Field and state widths.
  localparam int CMD_W      = 2;
  localparam int RAW_W      = 12;
  localparam int VAL_W      = 10;
  localparam int FRAC_W     = 8;
  localparam int Q_W        = VAL_W + FRAC_W;
  localparam int ALPHA_W    = 8;
  localparam int SUM_W      = 16;
  localparam int CNT_W      = 7;
  localparam int NUM_W      = SUM_W + FRAC_W;
  localparam int CFG_W      = 2;
  localparam int CFG_DATA_W = 8;

  // Trimmed mean divisor: one minimum and one maximum go away for groups of three or more.
  localparam bit TRIM  = (SAMPLES >= 3);
  localparam int DENOM = TRIM ? SAMPLES - 2 : SAMPLES;

  // Reciprocal of the divisor, rounded up. With a 6-bit headroom over the dividend
  // width, the truncated product equals the exact floor quotient for every dividend.
  localparam int RECIP_SH = NUM_W + 6;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) + DENOM - 1) / DENOM;

  localparam logic [RAW_W-1:0] RAW_MAX      = '1;
  localparam logic [VAL_W-1:0] VAL_MAX      = '1;
  localparam logic [Q_W-1:0]   FULL_SCALE_Q = {VAL_MAX, FRAC_W'(0)};

  // Configuration register indexes.
  localparam logic [CFG_W-1:0] CFG_ENABLED      = 2'd0;
  localparam logic [CFG_W-1:0] CFG_PITCH_ALPHA  = 2'd1;
  localparam logic [CFG_W-1:0] CFG_SLIDER_ALPHA = 2'd2;

  // Channel codes; CMD_NONE is an unknown channel that yields no result.
  typedef enum logic [CMD_W-1:0] {
    CMD_PITCH = 2'd0,
    CMD_MOD   = 2'd1,
    CMD_VEL   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // One item between pipeline stages. num holds the dividend of the pitch group
  // average, or the Q10.8 sample, or after division the Q10.8 value for the EMA.
  typedef struct packed {
    cmd_t             cmd;
    logic             zero;
    logic [NUM_W-1:0] num;
  } stme_item_t;

endpackage

FILE: rtl/stme_front.sv
// Front stage: sample scaling, last good value and pitch bend group accumulation.
// Depends on stme_pkg.
module stme_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       a_vld,
  input  stme_pkg::cmd_t             a_cmd,
  input  logic [stme_pkg::RAW_W-1:0] a_raw,
  input  logic                       a_ok,
  input  logic                       enabled,
  output logic                       a_ready,
  output logic                       b_vld,
  output stme_pkg::stme_item_t       b_item,
  input  logic                       b_ready
);
  import stme_pkg::*;

  logic                     b_vld_r;
  stme_item_t               b_item_r;
  stme_item_t               item_nxt;
  logic                     emit_nxt;
  logic                     take;
  logic [VAL_W-1:0]         last_good_r;
  logic [SUM_W-1:0]         group_sum_r;
  logic [VAL_W-1:0]         group_min_r;
  logic [VAL_W-1:0]         group_max_r;
  logic [CNT_W-1:0]         group_count_r;
  logic [RAW_W+VAL_W-1:0]   prod;
  logic [VAL_W-1:0]         q0;
  logic [RAW_W:0]           rem;
  logic [VAL_W-1:0]         scaled;
  logic [VAL_W-1:0]         v;
  logic [SUM_W-1:0]         sum_nxt;
  logic [VAL_W-1:0]         min_nxt;
  logic [VAL_W-1:0]         max_nxt;
  logic [CNT_W-1:0]         cnt_nxt;
  logic                     full;
  logic [SUM_W-1:0]         trim_sum;

  assign a_ready = !b_vld_r || b_ready;
  assign take    = a_vld && a_ready;
  assign b_vld   = b_vld_r;
  assign b_item  = b_item_r;

  // raw*1023/4095: take the quotient by 4096, then one correction step since
  // the remainder against 4095 stays below twice the divisor.
  always_comb begin
    prod   = {a_raw, VAL_W'(0)} - (RAW_W+VAL_W)'(a_raw);
    q0     = prod[RAW_W+VAL_W-1 -: VAL_W];
    rem    = (RAW_W+1)'(prod[RAW_W-1:0]) + (RAW_W+1)'(q0);
    scaled = q0 + VAL_W'(rem >= (RAW_W+1)'(RAW_MAX));
    v      = a_ok ? scaled : last_good_r;
  end

  // Group update and the trimmed sum once the group is full.
  always_comb begin
    sum_nxt  = group_sum_r + SUM_W'(v);
    min_nxt  = (v < group_min_r) ? v : group_min_r;
    max_nxt  = (v > group_max_r) ? v : group_max_r;
    cnt_nxt  = group_count_r + CNT_W'(1);
    full     = (cnt_nxt == CNT_W'(SAMPLES));
    trim_sum = TRIM ? sum_nxt - SUM_W'(min_nxt) - SUM_W'(max_nxt) : sum_nxt;
  end

  // Item handed to the divider stage.
  always_comb begin
    item_nxt.cmd  = a_cmd;
    item_nxt.zero = !enabled;
    item_nxt.num  = '0;
    emit_nxt      = 1'b1;
    if (enabled) begin
      if (a_cmd == CMD_PITCH) begin
        item_nxt.num = {trim_sum, FRAC_W'(0)};
        emit_nxt     = full;
      end else begin
        item_nxt.num = NUM_W'({v, FRAC_W'(0)});
      end
    end
  end

  // Stage register and channel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r       <= 1'b0;
      last_good_r   <= '0;
      group_sum_r   <= '0;
      group_min_r   <= VAL_MAX;
      group_max_r   <= '0;
      group_count_r <= '0;
    end else begin
      if (a_ready) begin
        b_vld_r <= a_vld && emit_nxt;
      end
      if (take && enabled) begin
        last_good_r <= v;
        if (a_cmd == CMD_PITCH) begin
          if (full) begin
            group_sum_r   <= '0;
            group_min_r   <= VAL_MAX;
            group_max_r   <= '0;
            group_count_r <= '0;
          end else begin
            group_sum_r   <= sum_nxt;
            group_min_r   <= min_nxt;
            group_max_r   <= max_nxt;
            group_count_r <= cnt_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      b_item_r <= item_nxt;
    end
  end

  // The group never holds a full count between items.
  a_count_low: assert property (@(posedge clk) disable iff (!rst_n)
    group_count_r < CNT_W'(SAMPLES))
    else $error("pitch group count reached the group size");

  // An empty group carries the cleared sum, minimum and maximum.
  a_empty_clear: assert property (@(posedge clk) disable iff (!rst_n)
    group_count_r == '0 |->
      group_sum_r == '0 && group_min_r == VAL_MAX && group_max_r == '0)
    else $error("empty pitch group is not cleared");

endmodule

FILE: rtl/stme_div.sv
// Divider stage: group sum over the trimmed count by reciprocal multiplication.
// Depends on stme_pkg.
module stme_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 b_vld,
  input  stme_pkg::stme_item_t b_item,
  output logic                 b_ready,
  output logic                 c_vld,
  output stme_pkg::stme_item_t c_item,
  input  logic                 c_ready
);
  import stme_pkg::*;

  logic                       c_vld_r;
  stme_item_t                 c_item_r;
  stme_item_t                 item_nxt;
  logic [NUM_W+RECIP_W-1:0]   prod;

  assign b_ready = !c_vld_r || c_ready;
  assign c_vld   = c_vld_r;
  assign c_item  = c_item_r;

  // Exact floor quotient for a pitch group; other channels pass through.
  always_comb begin
    prod     = (NUM_W+RECIP_W)'(b_item.num) * (NUM_W+RECIP_W)'(RECIP);
    item_nxt = b_item;
    if (b_item.cmd == CMD_PITCH) begin
      item_nxt.num = NUM_W'(prod >> RECIP_SH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (b_ready) begin
      c_vld_r <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      c_item_r <= item_nxt;
    end
  end

endmodule

FILE: rtl/stme_ema.sv
// EMA stage: per-channel moving averages and the result register.
// Depends on stme_pkg.
module stme_ema (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         c_vld,
  input  stme_pkg::stme_item_t         c_item,
  output logic                         c_ready,
  input  logic [stme_pkg::ALPHA_W-1:0] pitch_alpha,
  input  logic [stme_pkg::ALPHA_W-1:0] slider_alpha,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [stme_pkg::CMD_W-1:0]   out_source,
  output logic [stme_pkg::VAL_W-1:0]   out_smoothed_value
);
  import stme_pkg::*;

  localparam int BLEND_W = Q_W + ALPHA_W + 2;

  logic                   out_valid_r;
  cmd_t                   out_source_r;
  logic [VAL_W-1:0]       out_value_r;
  logic [Q_W-1:0]         pitch_avg_r;
  logic                   pitch_seeded_r;
  logic [Q_W-1:0]         mod_avg_r;
  logic [Q_W-1:0]         vel_avg_r;
  logic                   take;
  logic [Q_W-1:0]         x;
  logic [Q_W-1:0]         st;
  logic [ALPHA_W-1:0]     alpha;
  logic [ALPHA_W:0]       inv_alpha;
  logic [BLEND_W-1:0]     blend;
  logic [Q_W-1:0]         ema_nxt;

  assign c_ready            = !out_valid_r || !out_stall;
  assign take               = c_vld && c_ready;
  assign out_valid          = out_valid_r;
  assign out_source         = out_source_r;
  assign out_smoothed_value = out_value_r;

  // Select the channel's state and weight, then blend in the new value.
  always_comb begin
    x = (c_item.num > NUM_W'(FULL_SCALE_Q)) ? FULL_SCALE_Q : c_item.num[Q_W-1:0];
    case (c_item.cmd)
      CMD_PITCH: begin
        st    = pitch_avg_r;
        alpha = pitch_alpha;
      end
      CMD_MOD: begin
        st    = mod_avg_r;
        alpha = slider_alpha;
      end
      default: begin
        st    = vel_avg_r;
        alpha = slider_alpha;
      end
    endcase
    inv_alpha = (ALPHA_W+1)'(1 << ALPHA_W) - (ALPHA_W+1)'(alpha);
    blend     = BLEND_W'(st) * BLEND_W'(inv_alpha) + BLEND_W'(x) * BLEND_W'(alpha);
    ema_nxt   = blend[ALPHA_W +: Q_W];
    // The first pitch average seeds its EMA directly.
    if (c_item.cmd == CMD_PITCH && !pitch_seeded_r) begin
      ema_nxt = x;
    end
  end

  // Result register and channel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      pitch_avg_r    <= '0;
      pitch_seeded_r <= 1'b0;
      mod_avg_r      <= '0;
      vel_avg_r      <= '0;
    end else begin
      if (c_ready) begin
        out_valid_r <= c_vld;
      end
      if (take && !c_item.zero) begin
        case (c_item.cmd)
          CMD_PITCH: begin
            pitch_avg_r    <= ema_nxt;
            pitch_seeded_r <= 1'b1;
          end
          CMD_MOD: begin
            mod_avg_r <= ema_nxt;
          end
          CMD_VEL: begin
            vel_avg_r <= ema_nxt;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      out_source_r <= c_item.cmd;
      out_value_r  <= c_item.zero ? '0 : ema_nxt[Q_W-1 -: VAL_W];
    end
  end

  // Unknown channels are dropped before they reach the result register.
  a_no_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_source_r != CMD_NONE)
    else $error("result carries the unknown channel code");

  // The pitch EMA stays at its reset value until the first group seeds it.
  a_unseeded: assert property (@(posedge clk) disable iff (!rst_n)
    !pitch_seeded_r |-> pitch_avg_r == '0)
    else $error("pitch average changed before seeding");

endmodule

FILE: rtl/slider_trimmed_mean_ema.sv
// Slider sample conditioner: converter samples in, smoothed slider values out.
// Channels: in_* carries one sample (channel, 12-bit reading, read status) per item;
// out_* carries one smoothed 10-bit value with its channel. Both use valid/stall:
// an item moves on a rising edge with valid high and stall low.
// cfg_we/cfg_index/cfg_wdata write enabled, pitch_alpha and slider_alpha; the user
// writes them only while idle, which the block does not enforce. Pipeline: input
// register, scaling and group stage, reciprocal divider, EMA stage with the result
// register. Throughput is one item per cycle while out_stall is low; each stage
// holds at most one item. While enabled, pitch bend items give one result per full
// group; unknown channels give none. While the receiver stalls, the result register
// holds and the stages behind it keep filling until all are occupied, after which
// in_stall rises. Reset clears all averages, the pitch group and the last good
// value, disables the block and loads the default weights.
// Depends on stme_pkg, stme_front, stme_div and stme_ema.
module slider_trimmed_mean_ema (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [stme_pkg::CMD_W-1:0]      in_command,
  input  logic [stme_pkg::RAW_W-1:0]      in_raw_sample,
  input  logic                            in_read_ok,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [stme_pkg::CMD_W-1:0]      out_source,
  output logic [stme_pkg::VAL_W-1:0]      out_smoothed_value,
  input  logic                            cfg_we,
  input  logic [stme_pkg::CFG_W-1:0]      cfg_index,
  input  logic [stme_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import stme_pkg::*;

  logic               enabled_r;
  logic [ALPHA_W-1:0] pitch_alpha_r;
  logic [ALPHA_W-1:0] slider_alpha_r;
  logic               a_vld_r;
  cmd_t               a_cmd_r;
  logic [RAW_W-1:0]   a_raw_r;
  logic               a_ok_r;
  logic               a_ready;
  logic               b_vld;
  stme_item_t         b_item;
  logic               b_ready;
  logic               c_vld;
  stme_item_t         c_item;
  logic               c_ready;

  assign in_stall = a_vld_r && !a_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r      <= 1'b0;
      pitch_alpha_r  <= ALPHA_W'(31);
      slider_alpha_r <= ALPHA_W'(26);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLED:      enabled_r      <= cfg_wdata[0];
        CFG_PITCH_ALPHA:  pitch_alpha_r  <= cfg_wdata[ALPHA_W-1:0];
        CFG_SLIDER_ALPHA: slider_alpha_r <= cfg_wdata[ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register; items for the unknown channel are dropped here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (!in_stall) begin
      a_vld_r <= in_valid && (cmd_t'(in_command) != CMD_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      a_cmd_r <= cmd_t'(in_command);
      a_raw_r <= in_raw_sample;
      a_ok_r  <= in_read_ok;
    end
  end

  stme_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .a_vld   (a_vld_r),
    .a_cmd   (a_cmd_r),
    .a_raw   (a_raw_r),
    .a_ok    (a_ok_r),
    .enabled (enabled_r),
    .a_ready (a_ready),
    .b_vld   (b_vld),
    .b_item  (b_item),
    .b_ready (b_ready)
  );

  stme_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .b_vld   (b_vld),
    .b_item  (b_item),
    .b_ready (b_ready),
    .c_vld   (c_vld),
    .c_item  (c_item),
    .c_ready (c_ready)
  );

  stme_ema u_ema (
    .clk                (clk),
    .rst_n              (rst_n),
    .c_vld              (c_vld),
    .c_item             (c_item),
    .c_ready            (c_ready),
    .pitch_alpha        (pitch_alpha_r),
    .slider_alpha       (slider_alpha_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_source         (out_source),
    .out_smoothed_value (out_smoothed_value)
  );

endmodule
